/* hdl/bis_pkg.sv */
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants for the bounded integer set.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int DEF_DEPTH = 64;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 7;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 1 + POS_W + CNT_W + STAT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic fetch;
    logic move;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_move;
  } sts_t;

endpackage

/* hdl/bis_ctrl.sv */
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer for one request: scan, optional move of the last member, result.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output bis_pkg::cmd_t cmd,
  input  bis_pkg::sts_t sts
);
  import bis_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.need_move ? S_FETCH : S_FINISH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.finish) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_move_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> $past(state_r) == S_FETCH)
    else $error("move without fetch of the last member");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_vld_r || out_tready))
    else $error("result overwrites an untaken beat");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_tready)
    else $error("second beat accepted during a request");
`endif

endmodule

/* hdl/bis_dpath.sv */
// ----------------------------------------------------------------------------
// bis_dpath
// Member store, scan pointer, compare, count and result registers.
// ----------------------------------------------------------------------------
module bis_dpath #(
  parameter int DEPTH = bis_pkg::DEF_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bis_pkg::cmd_t                cmd,
  output bis_pkg::sts_t                sts,
  input  logic [bis_pkg::FUNC_W-1:0]   in_func,
  input  logic [bis_pkg::VALUE_W-1:0]  in_value,
  input  logic                         cap_we,
  input  logic [bis_pkg::CAP_W-1:0]    cap_wdata,
  output logic [bis_pkg::OUT_W-1:0]    res
);
  import bis_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;
  localparam int PW = (AW > POS_W) ? AW : POS_W;
  localparam int QW = (CW > CNT_W) ? CW : CNT_W;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  func_t              func_r;
  logic [VALUE_W-1:0] value_r;
  logic [CAP_W-1:0]   cap_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      scan_idx_r;
  logic               cmp_vld_r;
  logic [AW-1:0]      cmp_idx_r;
  logic               hit_r;
  logic [AW-1:0]      hit_pos_r;
  logic [OUT_W-1:0]   res_r;

  logic               issue;
  logic               match;
  logic               full;
  logic               do_add;
  status_t            stat;
  logic [CW-1:0]      last_idx;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [XW-1:0]      cnt_x, cap_x;
  logic [PW-1:0]      pos_x;
  logic [QW-1:0]      cnt_q;

  assign issue = cmd.scan && (func_r != FUNC_CLEAR) && !hit_r && (scan_idx_r < cnt_r);
  assign match = cmp_vld_r && !hit_r && (rd_data_r == value_r);

  assign sts.scan_done = !cmp_vld_r &&
                         (hit_r || (scan_idx_r >= cnt_r) || (func_r == FUNC_CLEAR));
  assign sts.need_move = (func_r == FUNC_REMOVE) && hit_r;

  // full when count reaches min(capacity, depth)
  assign cnt_x = XW'(cnt_r);
  assign cap_x = XW'(cap_r);
  assign full  = (cnt_x >= cap_x) || (cnt_r == CW'(DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    stat    = ST_OK;
    do_add  = 1'b0;
    unique case (func_r)
      FUNC_ADD: begin
        if (full) begin
          stat = ST_FULL;
        end else if (hit_r) begin
          stat = ST_PRESENT;
        end else begin
          do_add  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      FUNC_REMOVE: begin
        if (hit_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          stat = ST_ABSENT;
        end
      end
      FUNC_QUERY: begin
        if (!hit_r) begin
          stat = ST_ABSENT;
        end
      end
      FUNC_CLEAR: begin
        cnt_nxt = '0;
      end
      default: stat = ST_OK;
    endcase
  end

  assign last_idx = cnt_r - CW'(1);
  assign rd_addr  = cmd.fetch ? last_idx[AW-1:0] : scan_idx_r[AW-1:0];
  assign we       = cmd.move || (cmd.finish && do_add);
  assign wr_addr  = cmd.move ? hit_pos_r : cnt_r[AW-1:0];
  assign wr_data  = cmd.move ? rd_data_r : value_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      cnt_r      <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      hit_pos_r  <= '0;
    end else begin
      if (cap_we) begin
        cap_r <= cap_wdata;
      end
      if (cmd.start) begin
        scan_idx_r <= '0;
        cmp_vld_r  <= 1'b0;
        hit_r      <= 1'b0;
        hit_pos_r  <= '0;
      end else begin
        cmp_vld_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
        if (match) begin
          hit_r     <= 1'b1;
          hit_pos_r <= cmp_idx_r;
        end
      end
      if (cmd.finish) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
    end
    if (issue) begin
      cmp_idx_r <= scan_idx_r[AW-1:0];
    end
  end

  assign pos_x = PW'(hit_pos_r);
  assign cnt_q = QW'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= {stat, cnt_q[CNT_W-1:0], pos_x[POS_W-1:0], hit_r};
    end
  end

  assign res = res_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("member count above store depth");

  a_cnt_hold: assert property (@(posedge clk)
    rst_n && !cmd.finish |=> cnt_r == $past(cnt_r))
    else $error("member count changed outside result step");

  a_move_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> hit_r && (func_r == FUNC_REMOVE))
    else $error("slot overwrite without a removed member");
`endif

endmodule

/* hdl/bounded_integer_set.sv */
// ----------------------------------------------------------------------------
// bounded_integer_set
// Bounded set of 32-bit integers kept in an unordered store with a count.
// ----------------------------------------------------------------------------
// Each request adds, removes, queries or clears one value and returns one
// result beat with found, position, count and status. Membership is found by
// a linear scan of the member store, one member per cycle; a remove that
// hits then reads the last member and writes it into the freed slot, and a
// clear skips the scan. One request is in flight at a time; the next one is
// accepted while the previous result waits in the output register. The
// capacity register may be rewritten only while no request is in flight.
module bounded_integer_set #(
  parameter int DEPTH = bis_pkg::DEF_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bis_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [bis_pkg::FUNC_W-1:0]  in_tuser,   // [1:0] func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bis_pkg::OUT_W-1:0]   out_tdata,  // [0] found, [6:1] position,
                                                  // [13:7] count, [15:14] status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bis_pkg::CAP_W-1:0]   cfg_data    // capacity
);
  import bis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bis_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_func  (in_tuser),
    .in_value (in_tdata),
    .cap_we   (cfg_valid && cfg_ready),
    .cap_wdata(cfg_data),
    .res      (out_tdata)
  );

endmodule

/* sim/bounded_integer_set_test.sv */
// ----------------------------------------------------------------------------
// bounded_integer_set_test
// Self-checking bench for the bounded integer set.
// ----------------------------------------------------------------------------
// A short table of directed requests covers empty-set lookups, the extreme
// values, a member in slot 0, duplicate adds, the move of the last member on
// remove, clear, and the capacity corner cases. Then random request streams
// run under several capacities and handshake idling patterns. A set model in
// the bench predicts each result beat that the table does not give, and the
// monitor compares each beat field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module bounded_integer_set_test;
  import bis_pkg::*;

  localparam int SET_DEPTH  = DEF_DEPTH;
  localparam int LIMIT      = 1500000;
  localparam int SETTLE     = SET_DEPTH + 8;
  localparam int HOLD_LEN   = 400;
  localparam int N_PHASES   = 9;
  localparam int PHASE_ITEMS = 217;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    status_t          status;
  } set_result_t;

  typedef struct {
    bit                 is_cap;
    logic [CAP_W-1:0]   cap;
    func_t              func;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    set_result_t        want;
  } dir_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;
  logic [FUNC_W-1:0]  in_tuser   = FUNC_QUERY;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data   = CAP_RESET;

  // set model
  logic [VALUE_W-1:0] model_members [SET_DEPTH];
  int unsigned        model_count = 0;
  int unsigned        model_cap   = CAP_RESET;

  set_result_t results_due [$];
  dir_row_t    dir_rows [$];
  int          errors       = 0;
  int          cycle_count  = 0;
  int          send_idle    = 0;
  int          recv_stall   = 0;
  int          hold_requests = 0;
  int          hold_served  = 0;
  int          hold_left    = 0;

  bounded_integer_set dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("bounded_integer_set verification failed");
      $finish;
    end
  end

  // applies one request to the set model and returns the result it gives
  function automatic set_result_t apply_set_op(input func_t f, input logic [VALUE_W-1:0] v);
    set_result_t r;
    int unsigned slot;
    int unsigned room;
    bit hit;
    slot = 0;
    hit  = 1'b0;
    room = (model_cap < SET_DEPTH) ? model_cap : SET_DEPTH;
    r.status = ST_OK;
    if (f == FUNC_CLEAR) begin
      model_count = 0;
    end else begin
      for (int i = 0; i < model_count; i++) begin
        if (!hit && model_members[i] == v) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      case (f)
        FUNC_ADD: begin
          // full check wins over a duplicate
          if (model_count >= room) r.status = ST_FULL;
          else if (hit) r.status = ST_PRESENT;
          else begin
            model_members[model_count] = v;
            model_count++;
          end
        end
        FUNC_REMOVE: begin
          if (hit) begin
            model_count--;
            model_members[slot] = model_members[model_count];
          end else begin
            r.status = ST_ABSENT;
          end
        end
        default: begin
          if (!hit) r.status = ST_ABSENT;
        end
      endcase
    end
    r.found    = hit;
    r.position = slot[POS_W-1:0];
    r.count    = model_count[CNT_W-1:0];
    return r;
  endfunction

  // result monitor
  always @(posedge clk) begin : result_check
    set_result_t got;
    set_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found    = out_tdata[0];
      got.position = out_tdata[6:1];
      got.count    = out_tdata[13:7];
      got.status   = status_t'(out_tdata[15:14]);
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat: found=%0d position=%0d count=%0d status=%s",
                 $time, got.found, got.position, got.count, got.status.name());
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.count !== want.count || got.status !== want.status) begin
          $display("%0t: mismatch: expected found=%0d position=%0d count=%0d status=%s",
                   $time, want.found, want.position, want.count, want.status.name());
          $display("%0t:           actual found=%0d position=%0d count=%0d status=%s",
                   $time, got.found, got.position, got.count, got.status.name());
          errors++;
        end
      end
    end
  end

  // receiver side; a requested hold-off is counted here
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_item(input func_t f, input logic [VALUE_W-1:0] v,
                           input bit typed, input set_result_t want);
    set_result_t pred;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_set_op(f, v);
    results_due.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_cap = c;
  endtask

  function automatic set_result_t mk_result(input logic found, input int pos,
                                            input int cnt, input status_t st);
    set_result_t r;
    r.found    = found;
    r.position = pos[POS_W-1:0];
    r.count    = cnt[CNT_W-1:0];
    r.status   = st;
    return r;
  endfunction

  function automatic void row_cap(input int c);
    dir_row_t r;
    r.is_cap = 1'b1;
    r.cap    = c[CAP_W-1:0];
    r.func   = FUNC_QUERY;
    r.value  = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_op(input func_t f, input logic [VALUE_W-1:0] v);
    dir_row_t r;
    r.is_cap = 1'b0;
    r.cap    = '0;
    r.func   = f;
    r.value  = v;
    r.typed  = 1'b0;
    r.want   = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_chk(input func_t f, input logic [VALUE_W-1:0] v,
                                  input set_result_t want);
    row_op(f, v);
    dir_rows[$].typed = 1'b1;
    dir_rows[$].want  = want;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] base,
                                                    input int pool);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hffff_ffff;
        3: return 32'h8000_0000;
        default: return 32'h7fff_ffff;
      endcase
    end
    if (r < 14) return $urandom;
    return base + $urandom_range(pool - 1);
  endfunction

  function automatic func_t pick_func(input bit fill);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 1) return FUNC_CLEAR;
    if (fill) begin
      if (r < 60) return FUNC_ADD;
      if (r < 78) return FUNC_REMOVE;
      return FUNC_QUERY;
    end
    if (r < 28) return FUNC_ADD;
    if (r < 72) return FUNC_REMOVE;
    return FUNC_QUERY;
  endfunction

  int phase_cap  [N_PHASES] = '{64, 127, 1, 33, 0, 64, 5, 100, 127};
  int phase_pool [N_PHASES] = '{70, 70, 4, 16, 8, 70, 6, 40, 70};
  bit phase_fill [N_PHASES] = '{1, 1, 1, 0, 1, 1, 0, 1, 0};

  initial begin : main
    logic [VALUE_W-1:0] base;
    int mode;
    for (int i = 0; i < SET_DEPTH; i++) model_members[i] = '0;

    // empty set, extremes, slot 0 member, duplicates, move on remove, clear
    row_chk(FUNC_QUERY,  32'h0000_0000, mk_result(0, 0, 0, ST_ABSENT));
    row_chk(FUNC_REMOVE, 32'h0000_0005, mk_result(0, 0, 0, ST_ABSENT));
    row_chk(FUNC_ADD,    32'h8000_0000, mk_result(0, 0, 1, ST_OK));
    row_chk(FUNC_QUERY,  32'h8000_0000, mk_result(1, 0, 1, ST_OK));
    row_chk(FUNC_ADD,    32'h7fff_ffff, mk_result(0, 0, 2, ST_OK));
    row_chk(FUNC_ADD,    32'h8000_0000, mk_result(1, 0, 2, ST_PRESENT));
    row_op (FUNC_ADD,    32'h0000_0000);
    row_op (FUNC_ADD,    32'hffff_ffff);
    row_op (FUNC_QUERY,  32'hffff_ffff);
    row_op (FUNC_REMOVE, 32'h8000_0000);
    row_op (FUNC_QUERY,  32'hffff_ffff);
    row_chk(FUNC_CLEAR,  32'hffff_ffff, mk_result(0, 0, 0, ST_OK));
    row_chk(FUNC_QUERY,  32'hffff_ffff, mk_result(0, 0, 0, ST_ABSENT));
    // small capacity: full wins over duplicate
    row_cap(2);
    row_op (FUNC_ADD,    32'h0000_0001);
    row_op (FUNC_ADD,    32'h0000_0002);
    row_chk(FUNC_ADD,    32'h0000_0003, mk_result(0, 0, 2, ST_FULL));
    row_chk(FUNC_ADD,    32'h0000_0002, mk_result(1, 1, 2, ST_FULL));
    // capacity lowered below count keeps members
    row_cap(0);
    row_chk(FUNC_ADD,    32'h0000_0009, mk_result(0, 0, 2, ST_FULL));
    row_op (FUNC_REMOVE, 32'h0000_0001);
    row_chk(FUNC_ADD,    32'h0000_0009, mk_result(0, 0, 1, ST_FULL));
    // capacity above store depth
    row_cap(127);
    row_op (FUNC_ADD,    32'h0000_0009);
    row_chk(FUNC_CLEAR,  32'h5a5a_5a5a, mk_result(0, 0, 0, ST_OK));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cap) write_capacity(dir_rows[i].cap);
      else send_item(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed,
                     dir_rows[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_cap[p][CAP_W-1:0]);
      mode = p % 4;
      send_idle  = (mode == 1) ? 85 : (mode == 3) ? 9 : 0;
      recv_stall = (mode == 2) ? 85 : (mode == 3) ? 9 : 0;
      // long receiver hold-off while the sender keeps offering
      if (p == 5) hold_requests++;
      base = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(pick_func(phase_fill[p]), pick_value(base, phase_pool[p]), 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("bounded_integer_set verification clean");
    end else begin
      $display("bounded_integer_set verification failed");
    end
    $finish;
  end

endmodule
